// ----- design/fspa_pkg.sv -----
// ----------------------------------------------------------------------------
// fspa_pkg: shared definitions for the fixed slot pool allocator
// Field widths, register indexes, operation and status codes, and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fspa_pkg;

	// Fixed field widths
	localparam int OP_W        = 2;
	localparam int ADDR_W      = 32;
	localparam int OUT_IDX_W   = 10;
	localparam int ST_W        = 2;
	localparam int USE_W       = 11;
	localparam int CFG_W       = 32;
	localparam int REG_IDX_W   = 2;
	localparam int BASE_W      = 32;
	localparam int STRIDE_W    = 16;
	localparam int CAP_W       = 11;

	// Defaults and reset values
	localparam int MAX_SLOTS_DEF = 1024;
	localparam int ADDR_BITS_DEF = 32;
	localparam int STRIDE_RESET  = 16;
	localparam int CAP_RESET     = 1024;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_OOM   = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} st_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_BASE     = 2'd0,
		REG_STRIDE   = 2'd1,
		REG_CAPACITY = 2'd2
	} reg_t;

	// Controller to datapath
	typedef struct packed {
		logic load;      // latch item, clear result, prime divider
		logic pop;       // pop the free stack
		logic oom;       // mark out of memory
		logic pick;      // select popped index
		logic mul;       // index times stride
		logic add;       // add base
		logic div_step;  // one quotient bit
		logic settle;    // range/full check, push on free
		logic emit;      // load output register
	} fspa_cmd_t;

	// Datapath to controller
	typedef struct packed {
		op_t  op;
		logic is_null;
		logic empty;
		logic div_last;
	} fspa_sts_t;

endpackage

// ----- design/fspa_if.sv -----
// ----------------------------------------------------------------------------
// fspa_if: request and response channels
// Valid/ready channels carrying one request or one response per beat.
// ----------------------------------------------------------------------------
interface fspa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] slot_address;
	logic        address_is_null;

	modport source (output valid, operation, slot_address, address_is_null, input ready);
	modport sink   (input valid, operation, slot_address, address_is_null, output ready);
endinterface

interface fspa_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_address;
	logic [9:0]  result_index;
	logic [1:0]  status;
	logic [10:0] slots_in_use;

	modport source (output valid, result_address, result_index, status, slots_in_use,
		input ready);
	modport sink   (input valid, result_address, result_index, status, slots_in_use,
		output ready);
endinterface

// ----- design/fspa_ram.sv -----
// ----------------------------------------------------------------------------
// fspa_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fspa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/fspa_ctrl.sv -----
// ----------------------------------------------------------------------------
// fspa_ctrl: allocator sequencer
// Steps each request through pop, address build or division and check,
// and owns the response valid flag.
// ----------------------------------------------------------------------------
module fspa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  fspa_pkg::fspa_sts_t sts,
	output fspa_pkg::fspa_cmd_t cmd
);
	import fspa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_PICK,
		S_MUL,
		S_ADD,
		S_DIV,
		S_SETTLE,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   emit_ok;

	assign emit_ok   = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.op)
					OP_ALLOC: begin
						if (sts.empty) begin
							cmd.oom = 1'b1;
							state_d = S_DONE;
						end else begin
							cmd.pop = 1'b1;
							state_d = S_PICK;
						end
					end
					OP_FREE:  state_d = sts.is_null ? S_DONE : S_DIV;
					OP_QUERY: state_d = S_DIV;
					default:  state_d = S_DONE;
				endcase
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = S_DONE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_SETTLE;
				end
			end
			S_SETTLE: begin
				cmd.settle = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (emit_ok) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/fspa_dp.sv -----
// ----------------------------------------------------------------------------
// fspa_dp: allocator datapath
// Configuration registers, free index stack with fill mark, bit-serial
// divider, address multiply-add and the response register.
// ----------------------------------------------------------------------------
module fspa_dp #(
	parameter int MAX_SLOTS = fspa_pkg::MAX_SLOTS_DEF,
	parameter int ADDR_BITS = fspa_pkg::ADDR_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [fspa_pkg::REG_IDX_W-1:0]        wr_index,
	input  logic [fspa_pkg::CFG_W-1:0]            wr_data,
	input  logic [fspa_pkg::OP_W-1:0]             operation,
	input  logic [fspa_pkg::ADDR_W-1:0]           slot_address,
	input  logic                                  address_is_null,
	input  fspa_pkg::fspa_cmd_t                   cmd,
	output fspa_pkg::fspa_sts_t                   sts,
	output logic [fspa_pkg::ADDR_W-1:0]           result_address,
	output logic [fspa_pkg::OUT_IDX_W-1:0]        result_index,
	output logic [fspa_pkg::ST_W-1:0]             status,
	output logic [fspa_pkg::USE_W-1:0]            slots_in_use
);
	import fspa_pkg::*;

	localparam int IDX_W   = $clog2(MAX_SLOTS);
	localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
	localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int QW      = (ADDR_BITS > CNT_W) ? ADDR_BITS : CNT_W;
	localparam int PROD_W  = IDX_W + STRIDE_W;
	localparam int DCNT_W  = $clog2(ADDR_BITS);
	localparam int RST_CAP = (CAP_RESET > MAX_SLOTS) ? MAX_SLOTS : CAP_RESET;

	// Configuration and stack state
	logic [BASE_W-1:0]   base_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [CNT_W-1:0]    cap_q;
	logic [CNT_W-1:0]    depth_q;
	logic [CNT_W-1:0]    mark_q;   // lowest depth since reload; below it entries hold reset order
	logic [CNT_W-1:0]    used_q;

	// Item and work registers
	op_t                 op_q;
	logic                null_q;
	logic [ADDR_BITS-1:0] off_q;   // offset, shifts into quotient
	logic [STRIDE_W-1:0] rem_q;
	logic [DCNT_W-1:0]   dcnt_q;
	logic                hit_q;
	logic [IDX_W-1:0]    init_q;
	logic [IDX_W-1:0]    idx_q;
	logic [PROD_W-1:0]   prod_q;

	// Result and output registers
	logic [ADDR_W-1:0]    res_addr_q;
	logic [OUT_IDX_W-1:0] res_idx_q;
	st_t                  res_st_q;
	logic [ADDR_W-1:0]    out_addr_q;
	logic [OUT_IDX_W-1:0] out_idx_q;
	st_t                  out_st_q;
	logic [USE_W-1:0]     out_use_q;

	// Stack memory
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [IDX_W-1:0] ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic [IDX_W-1:0] ram_rdata;

	logic [CMP_W-1:0]    wr_cap_ext;
	logic [CNT_W-1:0]    wr_cap_eff;
	logic [STRIDE_W-1:0] div_stride;
	logic [STRIDE_W:0]   rem_sh;
	logic                q_bit;
	logic [QW-1:0]       quo_ext;
	logic                in_range;
	logic                stack_full;
	logic [IDX_W-1:0]    pick_idx;

	assign wr_cap_ext = CMP_W'(wr_data[CAP_W-1:0]);
	assign wr_cap_eff = (wr_cap_ext > CMP_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
	                                                      : CNT_W'(wr_cap_ext);

	assign div_stride = (stride_q == '0) ? STRIDE_W'(1) : stride_q;
	assign rem_sh     = {rem_q, off_q[ADDR_BITS-1]};
	assign q_bit      = (rem_sh >= {1'b0, div_stride});

	assign quo_ext    = QW'(off_q);
	assign in_range   = (quo_ext < QW'(cap_q));
	assign stack_full = (depth_q >= cap_q);
	assign pick_idx   = hit_q ? ram_rdata : init_q;

	assign ram_we    = cmd.settle && (op_q == OP_FREE) && in_range && !stack_full;
	assign ram_waddr = depth_q[IDX_W-1:0];
	assign ram_wdata = off_q[IDX_W-1:0];
	assign ram_raddr = IDX_W'(depth_q - CNT_W'(1));

	fspa_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_SLOTS)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.pop),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign sts.op       = op_q;
	assign sts.is_null  = null_q;
	assign sts.empty    = (depth_q == '0) || (depth_q > cap_q);
	assign sts.div_last = (dcnt_q == '0);

	// Configuration and stack bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			stride_q <= STRIDE_W'(STRIDE_RESET);
			cap_q    <= CNT_W'(RST_CAP);
			depth_q  <= CNT_W'(RST_CAP);
			mark_q   <= CNT_W'(RST_CAP);
			used_q   <= '0;
		end else begin
			if (wr_en) begin
				case (reg_t'(wr_index))
					REG_BASE:   base_q   <= wr_data[BASE_W-1:0];
					REG_STRIDE: stride_q <= wr_data[STRIDE_W-1:0];
					REG_CAPACITY: begin
						cap_q   <= wr_cap_eff;
						depth_q <= wr_cap_eff;
						mark_q  <= wr_cap_eff;
						used_q  <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.pop) begin
				depth_q <= depth_q - CNT_W'(1);
				used_q  <= used_q + CNT_W'(1);
				if (depth_q <= mark_q) begin
					mark_q <= depth_q - CNT_W'(1);
				end
			end
			if (ram_we) begin
				depth_q <= depth_q + CNT_W'(1);
				if (used_q != '0) begin
					used_q <= used_q - CNT_W'(1);
				end
			end
		end
	end

	// Item, divider, address build and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= op_t'(operation);
			null_q     <= address_is_null;
			off_q      <= ADDR_BITS'(slot_address) - ADDR_BITS'(base_q);
			rem_q      <= '0;
			dcnt_q     <= DCNT_W'(ADDR_BITS - 1);
			res_addr_q <= '0;
			res_idx_q  <= '0;
			res_st_q   <= ST_OK;
		end
		if (cmd.oom) begin
			res_st_q <= ST_OOM;
		end
		if (cmd.pop) begin
			hit_q  <= (depth_q > mark_q);
			init_q <= IDX_W'(cap_q - depth_q);
		end
		if (cmd.pick) begin
			idx_q     <= pick_idx;
			res_idx_q <= OUT_IDX_W'(pick_idx);
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(idx_q) * PROD_W'(stride_q);
		end
		if (cmd.add) begin
			res_addr_q <= ADDR_W'(ADDR_BITS'(base_q) + ADDR_BITS'(prod_q));
		end
		if (cmd.div_step) begin
			rem_q  <= q_bit ? STRIDE_W'(rem_sh - {1'b0, div_stride}) : rem_sh[STRIDE_W-1:0];
			off_q  <= {off_q[ADDR_BITS-2:0], q_bit};
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end
		if (cmd.settle) begin
			res_idx_q <= OUT_IDX_W'(off_q);
			if (!in_range) begin
				res_st_q <= ST_RANGE;
			end else if ((op_q == OP_FREE) && stack_full) begin
				res_st_q <= ST_FULL;
			end
		end
		if (cmd.emit) begin
			out_addr_q <= res_addr_q;
			out_idx_q  <= res_idx_q;
			out_st_q   <= res_st_q;
			out_use_q  <= USE_W'(used_q);
		end
	end

	assign result_address = out_addr_q;
	assign result_index   = out_idx_q;
	assign status         = out_st_q;
	assign slots_in_use   = out_use_q;

endmodule

// ----- design/fixed_slot_pool_allocator.sv -----
// Sequence per request: alloc steps dispatch (pop), pick, multiply, add and done; free
//   and index query step dispatch, the one-bit-per-cycle divider, settle and done;
//   failed alloc, null free and unused codes go from dispatch to done. One request in work at a time.
// A finished response waits in the output register while the next request is taken;
//   no new request is taken until the current one has been emitted.
// Reset: asynchronous, active low; the free stack counts as reloaded at once (fill mark).
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator: fixed-size slot allocator with free index stack
// Alloc pops a free slot index and returns base + index * stride; free maps
// an address back to its index, checks it and pushes it; index query reports the index
// and its range status without pushing it.
// ----------------------------------------------------------------------------
module fixed_slot_pool_allocator #(
	parameter int MAX_SLOTS = fspa_pkg::MAX_SLOTS_DEF,
	parameter int ADDR_BITS = fspa_pkg::ADDR_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [fspa_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [fspa_pkg::CFG_W-1:0]     wr_data,
	fspa_req_if.sink                       req,
	fspa_rsp_if.source                     rsp
);
	import fspa_pkg::*;

	fspa_cmd_t cmd;
	fspa_sts_t sts;

	// Sequencer: takes a request beat only when idle, then steps pop/pick/
	// multiply/add for alloc or the divider and check for free and query.
	// Hold the response in the output register until the sink takes the beat.
	fspa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: configuration registers, free stack RAM with fill mark,
	// divider, address multiply-add and response register.
	fspa_dp #(
		.MAX_SLOTS (MAX_SLOTS),
		.ADDR_BITS (ADDR_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.operation       (req.operation),
		.slot_address    (req.slot_address),
		.address_is_null (req.address_is_null),
		.cmd             (cmd),
		.sts             (sts),
		.result_address  (rsp.result_address),
		.result_index    (rsp.result_index),
		.status          (rsp.status),
		.slots_in_use    (rsp.slots_in_use)
	);

endmodule

// ----- sim/fixed_slot_pool_allocator_test.sv -----
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator_test: self-checking bench for the slot allocator
// Drives alloc, free and index query requests through the request channel,
// predicts every response from a private copy of the free stack and the
// registers, and compares each response beat field by field in order.
// ----------------------------------------------------------------------------
module fixed_slot_pool_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import fspa_pkg::*;

	localparam int unsigned POOL_SLOTS = MAX_SLOTS_DEF;
	// Operation code 3 and register index 3 are decoded by nobody.
	localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int unsigned HOLD_OFF_CYCLES = 400;

	typedef struct packed {
		logic [ADDR_W-1:0]    address;
		logic [OUT_IDX_W-1:0] index;
		st_t                  status;
		logic [USE_W-1:0]     in_use;
	} pool_reply_t;

	// Mirror of the allocator: registers, free index stack, use count, and the
	// responses still owed by the block.
	class slot_pool_tracker;
		logic [BASE_W-1:0]    base;
		logic [STRIDE_W-1:0]  stride;
		logic [CAP_W-1:0]     capacity;
		logic [OUT_IDX_W-1:0] free_slots[POOL_SLOTS];
		int unsigned          stack_depth;
		int unsigned          in_use;
		pool_reply_t          replies_due[$];
		int unsigned          mismatches;

		function new();
			base = '0;
			stride = STRIDE_W'(STRIDE_RESET);
			capacity = CAP_W'(CAP_RESET);
			mismatches = 0;
			reload();
		endfunction

		function int unsigned limit();
			return (capacity > POOL_SLOTS) ? POOL_SLOTS : int'(capacity);
		endfunction

		// Refill with descending indices so slot 0 sits on top.
		function void reload();
			int unsigned cap;
			cap = limit();
			for (int unsigned i = 0; i < cap; i++)
				free_slots[i] = OUT_IDX_W'(cap - 1 - i);
			stack_depth = cap;
			in_use = 0;
		endfunction

		function void write_register(logic [REG_IDX_W-1:0] which, logic [CFG_W-1:0] data);
			case (which)
				REG_BASE:     base = data[BASE_W-1:0];
				REG_STRIDE:   stride = data[STRIDE_W-1:0];
				REG_CAPACITY: begin
					capacity = data[CAP_W-1:0];
					reload();
				end
				default: ;
			endcase
		endfunction

		function logic [ADDR_W-1:0] slot_of(logic [ADDR_W-1:0] addr);
			logic [ADDR_W-1:0] divisor;
			logic [ADDR_W-1:0] offset;
			divisor = (stride == 0) ? 1 : ADDR_W'(stride);
			offset = addr - base;
			return offset / divisor;
		endfunction

		// Apply one accepted request and queue the response it must produce.
		function pool_reply_t note_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
			logic is_null);
			pool_reply_t      r;
			logic [ADDR_W-1:0] slot;
			int unsigned      cap;
			r = '0;
			r.status = ST_OK;
			cap = limit();
			case (op)
				OP_ALLOC: begin
					if (stack_depth == 0 || stack_depth > cap) begin
						r.status = ST_OOM;
					end else begin
						stack_depth--;
						in_use++;
						r.index = free_slots[stack_depth];
						r.address = base + ADDR_W'(r.index) * ADDR_W'(stride);
					end
				end
				OP_FREE: begin
					if (!is_null) begin
						slot = slot_of(addr);
						r.index = slot[OUT_IDX_W-1:0];
						if (slot >= cap) begin
							r.status = ST_RANGE;
						end else if (stack_depth >= cap) begin
							r.status = ST_FULL;
						end else begin
							free_slots[stack_depth] = slot[OUT_IDX_W-1:0];
							stack_depth++;
							if (in_use > 0)
								in_use--;
						end
					end
				end
				OP_QUERY: begin
					slot = slot_of(addr);
					r.index = slot[OUT_IDX_W-1:0];
					if (slot >= cap)
						r.status = ST_RANGE;
				end
				default: ;
			endcase
			r.in_use = USE_W'(in_use);
			replies_due.push_back(r);
			return r;
		endfunction

		function void check_reply(pool_reply_t got);
			pool_reply_t want;
			if (replies_due.size() == 0) begin
				$display("%0t: response with none outstanding: %h", $time, got);
				mismatches++;
				return;
			end
			want = replies_due.pop_front();
			if (got.address !== want.address) begin
				$display("%0t: result_address expected %h, got %h", $time, want.address,
					got.address);
				mismatches++;
			end
			if (got.index !== want.index) begin
				$display("%0t: result_index expected %h, got %h", $time, want.index, got.index);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
				mismatches++;
			end
			if (got.in_use !== want.in_use) begin
				$display("%0t: slots_in_use expected %0d, got %0d", $time, want.in_use,
					got.in_use);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return replies_due.size();
		endfunction

		function void flag_missing();
			foreach (replies_due[i]) begin
				$display("%0t: response never arrived, expected %h", $time, replies_due[i]);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0] wr_data;

	fspa_req_if req_ch();
	fspa_rsp_if rsp_ch();

	fixed_slot_pool_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	slot_pool_tracker tracker = new();

	// Indices handed out and not yet returned; feeds well-formed frees.
	int unsigned held_slots[$];
	// Bumped by the stimulus side to make the response side hold off.
	int unsigned hold_off_asks = 0;
	int unsigned items_sent = 0;
	bit sender_calm = 1'b0;

	// Idle length: mostly none, some short, a few long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return 0;
		if (roll < 96)
			return $urandom_range(1, 4);
		return $urandom_range(12, 60);
	endfunction

	// Register write: one cycle with wr_en high, then wr_en low again before the task returns.
	task automatic write_reg(input logic [REG_IDX_W-1:0] which, input logic [CFG_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= which;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		tracker.write_register(which, data);
		@(posedge clk);
	endtask

	// Offer one request beat and hold it until the block takes it. Valid stays
	// high afterwards so back-to-back beats never toggle it within one step.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
		input logic is_null);
		int unsigned gap;
		pool_reply_t r;
		gap = sender_calm ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.slot_address <= addr;
		req_ch.address_is_null <= is_null;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		r = tracker.note_request(op, addr, is_null);
		if (op == OP_ALLOC && r.status == ST_OK)
			held_slots.push_back(r.index);
		items_sent++;
		// Switch between stretches with and without idle gaps.
		if (items_sent % 50 == 0)
			sender_calm = ($urandom_range(0, 3) == 0);
	endtask

	task automatic release_request();
		req_ch.valid <= 1'b0;
	endtask

	task automatic wait_until_drained();
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// Drain, reprogram base and stride, and optionally capacity (which reloads
	// the free stack and forgets every held slot).
	task automatic start_phase(input logic [CFG_W-1:0] base_word,
		input logic [CFG_W-1:0] stride_word, input logic [CFG_W-1:0] cap_word,
		input bit load_cap);
		release_request();
		wait_until_drained();
		write_reg(REG_BASE, base_word);
		write_reg(REG_STRIDE, stride_word);
		if (load_cap) begin
			write_reg(REG_CAPACITY, cap_word);
			held_slots.delete();
		end
	endtask

	// One random request. Most traffic is allocs and frees of held slots, so
	// the stack drains and refills; the rest is queries, stray frees, double
	// frees, null frees and the unused code.
	task automatic send_random();
		int unsigned pick;
		int unsigned cap;
		int unsigned span;
		int unsigned pos;
		int unsigned idx;
		logic [ADDR_W-1:0] addr;
		pick = $urandom_range(0, 99);
		cap = tracker.limit();
		span = (tracker.stride == 0) ? 1 : tracker.stride;
		if (pick < 40) begin
			send_item(OP_ALLOC, $urandom, 1'($urandom));
		end else if (pick < 65 && held_slots.size() > 0) begin
			pos = $urandom_range(0, held_slots.size() - 1);
			idx = held_slots[pos];
			held_slots.delete(pos);
			// Any byte inside the slot maps back to the same index.
			addr = tracker.base + idx * span + $urandom_range(0, span - 1);
			send_item(OP_FREE, addr, 1'b0);
		end else if (pick < 73) begin
			send_item(OP_FREE, $urandom, 1'b0);
		end else if (pick < 77) begin
			send_item(OP_FREE, $urandom, 1'b1);
		end else if (pick < 89) begin
			if (held_slots.size() > 0 && $urandom_range(0, 1) == 1)
				addr = tracker.base + held_slots[$urandom_range(0, held_slots.size() - 1)] * span;
			else
				addr = $urandom;
			send_item(OP_QUERY, addr, 1'($urandom));
		end else if (pick < 93) begin
			send_item(OP_UNUSED, $urandom, 1'($urandom));
		end else if (cap > 0) begin
			// Free an in-range slot whether or not it is held.
			idx = $urandom_range(0, cap - 1);
			send_item(OP_FREE, tracker.base + idx * span, 1'b0);
		end else begin
			send_item(OP_ALLOC, $urandom, 1'($urandom));
		end
	endtask

	task automatic run_random(input int unsigned count);
		for (int unsigned k = 0; k < count; k++)
			send_random();
	endtask

	// Response side: check each beat, idle at random, and honor long hold-offs.
	initial begin : reply_sink
		int unsigned stall_left;
		int unsigned hold_off_seen;
		int unsigned cycle_count;
		bit calm;
		pool_reply_t got;
		stall_left = 0;
		hold_off_seen = 0;
		cycle_count = 0;
		calm = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.address = rsp_ch.result_address;
				got.index = rsp_ch.result_index;
				got.status = st_t'(rsp_ch.status);
				got.in_use = rsp_ch.slots_in_use;
				tracker.check_reply(got);
			end
			cycle_count++;
			if (cycle_count % 128 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (hold_off_asks != hold_off_seen) begin
				hold_off_seen = hold_off_asks;
				stall_left = HOLD_OFF_CYCLES;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_BASE;
		wr_data = '0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_ALLOC;
		req_ch.slot_address = '0;
		req_ch.address_is_null = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: base 0, stride 16, full 1024-slot stack.
		send_item(OP_QUERY, 32'h0000_0000, 1'b0);
		send_item(OP_QUERY, 32'hFFFF_FFFF, 1'b1);     // far out of range
		send_item(OP_FREE, 32'h0000_0000, 1'b0);      // stack already full
		send_item(OP_FREE, 32'hFFFF_FFFF, 1'b1);      // null free, ignored
		send_item(OP_UNUSED, 32'hFFFF_FFFF, 1'b1);
		send_item(OP_ALLOC, 32'h0, 1'b0);
		send_item(OP_ALLOC, 32'h0, 1'b0);
		send_item(OP_ALLOC, 32'h0, 1'b0);
		send_item(OP_FREE, 32'd31, 1'b0);             // last byte of slot 1
		send_item(OP_ALLOC, 32'h0, 1'b0);             // slot 1 comes back
		send_item(OP_FREE, 32'd16384, 1'b0);          // one past the last slot
		send_item(OP_QUERY, 32'd16383, 1'b0);

		// Base near the top, widest stride, two slots: addresses wrap.
		start_phase(32'hFFFF_FFF0, 32'h0000_FFFF, 32'd2, 1'b1);
		send_item(OP_ALLOC, 32'h0, 1'b0);
		send_item(OP_ALLOC, 32'h0, 1'b0);
		send_item(OP_ALLOC, 32'h0, 1'b0);             // pool empty
		send_item(OP_FREE, 32'h0000_FFEE, 1'b0);
		send_item(OP_FREE, 32'h0000_FFEF, 1'b0);
		send_item(OP_FREE, 32'hFFFF_FFF0, 1'b0);      // stack full again
		send_item(OP_QUERY, 32'h0000_0000, 1'b0);     // below base, wraps to slot 0

		// Zero stride and zero capacity; upper data bits must be dropped.
		start_phase(32'h0000_0000, 32'hFFFF_0000, 32'hFFFF_F800, 1'b1);
		send_item(OP_ALLOC, 32'h0, 1'b0);
		send_item(OP_FREE, 32'h0, 1'b0);
		send_item(OP_QUERY, 32'h0, 1'b0);

		// Capacity above the slot count clamps to the slot count.
		start_phase(32'h0000_0000, 32'h0000_FFFF, 32'h0000_07FF, 1'b1);
		send_item(OP_ALLOC, 32'h0, 1'b0);
		send_item(OP_QUERY, 32'd67042305, 1'b0);      // slot 1023
		send_item(OP_FREE, 32'd67107840, 1'b0);       // slot 1024

		// Large pool; stall the response side so the request side backs up.
		start_phase(32'h1000_0000, 32'd64, 32'd1024, 1'b1);
		run_random(10);
		hold_off_asks <= hold_off_asks + 1;
		run_random(110);

		// Single slot, byte stride.
		start_phase($urandom, 32'd1, 32'd1, 1'b1);
		run_random(60);

		// Top base, widest stride with junk above it, clamped capacity.
		start_phase(32'hFFFF_FFFF, {16'($urandom), 16'hFFFF}, 32'd2047, 1'b1);
		run_random(80);

		// Move base and stride without reloading; pause mid-way until idle.
		start_phase($urandom, $urandom_range(1, 300), 32'd0, 1'b0);
		run_random(40);
		release_request();
		wait_until_drained();
		run_random(40);

		start_phase($urandom, 32'd0, 32'd0, 1'b1);
		run_random(30);

		start_phase($urandom, 32'd0, 32'd5, 1'b1);
		run_random(60);

		start_phase($urandom, $urandom_range(1, 65535), $urandom_range(1, 64), 1'b1);
		write_reg(REG_SPARE, $urandom);
		run_random(100);

		start_phase(32'h0000_0000, 32'd16, 32'd1024, 1'b1);
		run_random(130);

		// Let the last responses out, bounded, then a short quiet spell.
		release_request();
		for (int k = 0; k < 5000 && tracker.pending() != 0; k++)
			@(posedge clk);
		repeat (40) @(posedge clk);
		tracker.flag_missing();
		if (tracker.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin : watchdog
		#4ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- fixed_slot_pool_allocator.f -----
design/fspa_pkg.sv
design/fspa_if.sv
design/fspa_ram.sv
design/fspa_ctrl.sv
design/fspa_dp.sv
design/fixed_slot_pool_allocator.sv
sim/fixed_slot_pool_allocator_test.sv
